>>> sv/sprite_quad_vertex_setup_assert.svh
// Assertion macros used by the sprite quad vertex setup port checker.
`ifndef SPRITE_QUAD_VERTEX_SETUP_ASSERT_SVH
`define SPRITE_QUAD_VERTEX_SETUP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SQVS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SQVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/sqvs_pkg.sv
// Types, constants and tables for the sprite quad vertex setup block.
package sqvs_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int POS_FRAC_BITS = 8;
  localparam int PH_SHIFT      = 32 - ANGLE_BITS;
  localparam int RND_SH        = 38 - POS_FRAC_BITS;
  localparam int CORDIC_STEPS  = 16;
  localparam int CORDIC_STAGES = CORDIC_STEPS / 2;
  localparam int VERTS         = 6;

  localparam logic signed [19:0] CORDIC_K  = 20'sd39797;
  localparam logic signed [17:0] TRIG_ONE  = 18'sd65536;
  localparam logic signed [16:0] QUAD_ONE  = 17'sd16384;
  localparam logic [2:0]         LAST_CORNER = 3'(VERTS - 1);
  localparam logic signed [56:0] OUT_MAX   = 57'sd8388607;
  localparam logic signed [56:0] OUT_MIN   = -57'sd8388608;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  typedef struct packed {
    logic signed [15:0] angle;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic        [19:0] size_w;
    logic        [19:0] size_h;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic        [15:0] tex_u0;
    logic        [15:0] tex_v0;
    logic        [15:0] tex_u1;
    logic        [15:0] tex_v1;
  } sprite_in_t;

  typedef struct packed {
    logic signed [23:0] vert_x;
    logic signed [23:0] vert_y;
    logic        [15:0] vert_u;
    logic        [15:0] vert_v;
    logic        [2:0]  corner_index;
    logic               last_vertex;
  } vertex_out_t;

  typedef struct packed {
    logic signed [17:0] s;
    logic signed [17:0] c;
    sprite_in_t         spr;
  } trig_t;

  // Right column of the quad: bottom-right and both top-right corners.
  function automatic logic corner_qx(input logic [2:0] k);
    return (k == 3'd1) || (k == 3'd2) || (k == 3'd3);
  endfunction

  // Top row of the quad: both top-right corners and top-left.
  function automatic logic corner_qy(input logic [2:0] k);
    return (k == 3'd2) || (k == 3'd3) || (k == 3'd4);
  endfunction

endpackage

>>> sv/sqvs_cordic.sv
// Pipelined CORDIC sine/cosine unit, two rotation steps per stage.
module sqvs_cordic import sqvs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_vld,
  input  sprite_in_t in_spr,
  output logic       out_vld,
  output trig_t      out_trig
);

  typedef struct packed {
    logic               neg;
    logic               zero;
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [31:0] z;
    sprite_in_t         spr;
  } cord_st_t;

  logic     vld_r [CORDIC_STAGES+1];
  cord_st_t st_r  [CORDIC_STAGES+1];
  cord_st_t st0_nxt;
  logic     trig_vld_r;
  trig_t    trig_r, trig_nxt;

  // Phase setup: fold the middle quadrants by half a turn.
  always_comb begin
    logic [31:0] ph;
    logic [31:0] ph_f;
    ph = 32'($unsigned(32'(in_spr.angle))) << PH_SHIFT;
    st0_nxt.neg  = ph[31] ^ ph[30];
    st0_nxt.zero = (ph == 32'd0);
    ph_f = st0_nxt.neg ? (ph ^ 32'h80000000) : ph;
    st0_nxt.z    = $signed(ph_f);
    st0_nxt.x    = CORDIC_K;
    st0_nxt.y    = 20'sd0;
    st0_nxt.spr  = in_spr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    st_r[0] <= st0_nxt;
  end

  for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_stage
    cord_st_t st_nxt;

    always_comb begin
      cord_st_t   t;
      logic signed [19:0] xs;
      logic signed [19:0] ys;
      t = st_r[j];
      for (int k = 0; k < 2; k++) begin
        xs = t.x >>> (2*j + k);
        ys = t.y >>> (2*j + k);
        if (!t.z[31]) begin
          t.x = t.x - ys;
          t.y = t.y + xs;
          t.z = t.z - $signed(ATAN_TAB[2*j + k]);
        end else begin
          t.x = t.x + ys;
          t.y = t.y - xs;
          t.z = t.z + $signed(ATAN_TAB[2*j + k]);
        end
      end
      st_nxt = t;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else begin
        vld_r[j+1] <= vld_r[j];
      end
      st_r[j+1] <= st_nxt;
    end
  end

  always_comb begin
    cord_st_t f;
    f = st_r[CORDIC_STAGES];
    trig_nxt.spr = f.spr;
    if (f.zero) begin
      trig_nxt.s = 18'sd0;
      trig_nxt.c = TRIG_ONE;
    end else if (f.neg) begin
      trig_nxt.s = 18'(-f.y);
      trig_nxt.c = 18'(-f.x);
    end else begin
      trig_nxt.s = 18'(f.y);
      trig_nxt.c = 18'(f.x);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_vld_r <= 1'b0;
    end else begin
      trig_vld_r <= vld_r[CORDIC_STAGES];
    end
    trig_r <= trig_nxt;
  end

  assign out_vld  = trig_vld_r;
  assign out_trig = trig_r;

endmodule

>>> sv/sqvs_vertex.sv
// Corner sequencer and three-stage scale, rotate and translate pipeline.
module sqvs_vertex import sqvs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  trig_t       in_trig,
  output logic        out_vld,
  output vertex_out_t out_vert
);

  // Corner sequencer.
  logic       act_r, act_nxt;
  logic [2:0] k_r, k_nxt;
  trig_t      hold_r;

  always_comb begin
    act_nxt = act_r;
    k_nxt   = k_r;
    if (in_vld) begin
      act_nxt = 1'b1;
      k_nxt   = 3'd0;
    end else if (act_r) begin
      if (k_r == LAST_CORNER) begin
        act_nxt = 1'b0;
      end else begin
        k_nxt = k_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      k_r   <= 3'd0;
    end else begin
      act_r <= act_nxt;
      k_r   <= k_nxt;
    end
    if (in_vld) begin
      hold_r <= in_trig;
    end
  end

  // Stage 1: corner offsets times sine and cosine.
  logic               v1_vld_r;
  logic signed [34:0] pca_r, psb_r, psa_r, pcb_r;
  logic signed [34:0] pca_nxt, psb_nxt, psa_nxt, pcb_nxt;
  logic        [19:0] w1_r, h1_r;
  logic signed [23:0] px1_r, py1_r;
  logic        [15:0] u1_r, v1_r;
  logic        [2:0]  k1_r;

  always_comb begin
    logic signed [16:0] a;
    logic signed [16:0] b;
    a = (corner_qx(k_r) ? QUAD_ONE : 17'sd0) - 17'(hold_r.spr.origin_x);
    b = (corner_qy(k_r) ? QUAD_ONE : 17'sd0) - 17'(hold_r.spr.origin_y);
    pca_nxt = 35'(hold_r.c) * 35'(a);
    psb_nxt = 35'(hold_r.s) * 35'(b);
    psa_nxt = 35'(hold_r.s) * 35'(a);
    pcb_nxt = 35'(hold_r.c) * 35'(b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_vld_r <= 1'b0;
    end else begin
      v1_vld_r <= act_r;
    end
    pca_r <= pca_nxt;
    psb_r <= psb_nxt;
    psa_r <= psa_nxt;
    pcb_r <= pcb_nxt;
    w1_r  <= hold_r.spr.size_w;
    h1_r  <= hold_r.spr.size_h;
    px1_r <= hold_r.spr.pos_x;
    py1_r <= hold_r.spr.pos_y;
    u1_r  <= corner_qx(k_r) ? hold_r.spr.tex_u1 : hold_r.spr.tex_u0;
    v1_r  <= corner_qy(k_r) ? hold_r.spr.tex_v1 : hold_r.spr.tex_v0;
    k1_r  <= k_r;
  end

  // Stage 2: scale by the sprite size.
  logic               v2_vld_r;
  logic signed [55:0] tca_r, tsb_r, tsa_r, tcb_r;
  logic signed [23:0] px2_r, py2_r;
  logic        [15:0] u2_r, v2_r;
  logic        [2:0]  k2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_vld_r <= 1'b0;
    end else begin
      v2_vld_r <= v1_vld_r;
    end
    tca_r <= 56'(pca_r) * 56'($signed({1'b0, w1_r}));
    tsb_r <= 56'(psb_r) * 56'($signed({1'b0, h1_r}));
    tsa_r <= 56'(psa_r) * 56'($signed({1'b0, w1_r}));
    tcb_r <= 56'(pcb_r) * 56'($signed({1'b0, h1_r}));
    px2_r <= px1_r;
    py2_r <= py1_r;
    u2_r  <= u1_r;
    v2_r  <= v1_r;
    k2_r  <= k1_r;
  end

  // Stage 3: combine, round half up, translate and saturate.
  function automatic logic signed [23:0] place(input logic signed [56:0] rot,
                                               input logic signed [23:0] pos);
    logic signed [56:0] q;
    q = ((rot + (57'sd1 <<< (RND_SH - 1))) >>> RND_SH) + 57'(pos);
    if (q > OUT_MAX) begin
      return 24'(OUT_MAX);
    end else if (q < OUT_MIN) begin
      return 24'(OUT_MIN);
    end
    return 24'(q);
  endfunction

  logic        out_vld_r;
  vertex_out_t out_r, out_nxt;

  always_comb begin
    out_nxt.vert_x       = place(57'(tca_r) - 57'(tsb_r), px2_r);
    out_nxt.vert_y       = place(57'(tsa_r) + 57'(tcb_r), py2_r);
    out_nxt.vert_u       = u2_r;
    out_nxt.vert_v       = v2_r;
    out_nxt.corner_index = k2_r;
    out_nxt.last_vertex  = (k2_r == LAST_CORNER);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= v2_vld_r;
    end
    out_r <= out_nxt;
  end

  assign out_vld  = out_vld_r;
  assign out_vert = out_r;

endmodule

>>> sv/sprite_quad_vertex_setup.sv
// Sprite quad vertex setup: one sprite in, six vertices of two triangles out.
// The first vertex follows the start transfer through the CORDIC pipeline, the corner sequencer
// and the three vertex stages; the rest follow one a cycle, set by the single vertex datapath.
// busy is high after each start transfer while gap_r counts down; a new sprite may then follow.
// Reset (rst_n low, synchronous) clears all valid bits, the corner sequencer and busy.
// The receiver cannot stall: each vertex is shown for exactly one cycle with out_valid.
module sprite_quad_vertex_setup import sqvs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  sprite_in_t  in_data,
  output logic        out_valid,
  output vertex_out_t out_data
);

  // Issue spacing: a sprite occupies the vertex datapath until its last corner, so the
  // input is held off after each transfer while gap_r counts down. Since sprites stay
  // spaced that way through the fixed-latency CORDIC pipeline, the corner
  // sequencer never sees a new sprite before it has finished the previous one.
  logic [2:0] gap_r, gap_nxt;
  logic       acc;

  assign acc  = start && !busy;
  assign busy = (gap_r != 3'd0);

  always_comb begin
    gap_nxt = gap_r;
    if (acc) begin
      gap_nxt = 3'(VERTS - 1);
    end else if (gap_r != 3'd0) begin
      gap_nxt = gap_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= 3'd0;
    end else begin
      gap_r <= gap_nxt;
    end
  end

  // Sine and cosine of the sprite angle, with the sprite carried alongside.
  logic  trig_vld;
  trig_t trig;

  sqvs_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (acc),
    .in_spr   (in_data),
    .out_vld  (trig_vld),
    .out_trig (trig)
  );

  // Six corners a sprite, each scaled, rotated, translated and saturated.
  sqvs_vertex u_vertex (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (trig_vld),
    .in_trig  (trig),
    .out_vld  (out_valid),
    .out_vert (out_data)
  );

endmodule

>>> sv/sqvs_checker.sv
// Port-level checker for the sprite quad vertex setup, bound to the top level.
`include "sprite_quad_vertex_setup_assert.svh"

module sqvs_port_checker import sqvs_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input vertex_out_t out_data
);

  `SQVS_ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy, "busy low after transfer")

  `SQVS_ASSERT_IMPL(a_last_flag, clk, rst_n, out_valid, out_data.last_vertex == (out_data.corner_index == LAST_CORNER), "last flag mismatch")

  `SQVS_ASSERT_NEXT(a_run_continues, clk, rst_n, out_valid && !out_data.last_vertex, out_valid && (out_data.corner_index == 3'($past(out_data.corner_index) + 3'd1)), "vertex run broken")

  `SQVS_ASSERT_IMPL(a_run_start, clk, rst_n, out_valid && (out_data.corner_index != 3'd0), $past(out_valid), "vertex run without start")

endmodule

bind sprite_quad_vertex_setup sqvs_port_checker u_sqvs_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
